// ===== hw/rtl/ppi_pkg.sv =====
package ppi_pkg;

	localparam logic signed [17:0] HEAD_PI     = 18'sd12868;
	localparam logic signed [17:0] HEAD_TWO_PI = 18'sd25736;

	typedef struct packed {
		logic               func;
		logic [9:0]         index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [15:0] point_heading;
		logic signed [15:0] point_curvature;
		logic [31:0]        point_arc;
		logic [31:0]        query_arc;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [15:0] out_heading;
		logic signed [15:0] out_curvature;
		logic [31:0]        out_arc;
		logic               table_empty;
	} result_t;

	// one table row
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] h;
		logic signed [15:0] k;
		logic [31:0]        s;
	} entry_t;

	// classified command handed from front to back
	typedef struct packed {
		logic  is_query;
		logic  wr_ok;
		item_t item;
	} job_t;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic REG_PATH_LENGTH = 1'b0;
	localparam logic REG_POINT_COUNT = 1'b1;

endpackage

// ===== hw/rtl/ppi_front.sv =====
module ppi_front import ppi_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t item,
	output logic  busy,
	output logic  job_valid,
	output job_t  job,
	input  logic  job_pop
);

	localparam int QD = 4;
	localparam int PW = $clog2(QD);

	job_t          queue_q [QD];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   fill_q;
	logic          push, pop;
	job_t          incoming;

	assign busy      = (fill_q == (PW+1)'(QD));
	assign push      = start && !busy;
	assign job_valid = (fill_q != '0);
	assign pop       = job_pop && job_valid;
	assign job       = queue_q[rd_ptr_q];

	always_comb begin
		incoming.is_query = (item.func == FUNC_QUERY);
		incoming.wr_ok    = (32'(item.index) < 32'(MAX_POINTS));
		incoming.item     = item;
	end

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= incoming;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/ppi_back.sv =====
module ppi_back import ppi_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_pop,
	input  logic [31:0] path_length,
	input  logic [10:0] point_count,
	output logic        result_valid,
	output result_t     result
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SRCH  = 4'd1;
	localparam logic [3:0] ST_SCMP  = 4'd2;
	localparam logic [3:0] ST_FETCH = 4'd3;
	localparam logic [3:0] ST_LATA  = 4'd4;
	localparam logic [3:0] ST_LATB  = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_ACC   = 4'd8;

	entry_t mem_q [MAX_POINTS];
	entry_t rdata_s1;
	logic   mem_we;
	logic [AW-1:0] raddr, waddr;
	entry_t wentry;

	logic [3:0]    state_q;
	logic [CW-1:0] n_q, lo_q, hi_q, mid_q, mid, n_eff;
	logic [31:0]   s_q, s_clamp;
	logic          edge_q, run_q;
	entry_t        ea_q, eb_q;
	logic [31:0]   gap_q, rem_q, gap, num;
	logic [15:0]   t_q;
	logic [4:0]    div_cnt_q;
	logic signed [17:0] diff_q;
	logic [2:0]    k_q;
	logic signed [33:0] base_sel, d_sel;
	logic signed [33:0] base_s1;
	logic signed [51:0] prod_s1, acc;
	logic signed [35:0] val;
	logic signed [15:0] h_sat;
	logic [32:0]   rem2;
	result_t       build_q;
	logic          res_fire;

	assign job_pop = (state_q == ST_IDLE) && job_valid;
	assign mem_we  = job_pop && !job.is_query && job.wr_ok;
	assign waddr   = AW'(job.item.index);

	always_comb begin
		wentry.x = job.item.point_x;
		wentry.y = job.item.point_y;
		wentry.h = job.item.point_heading;
		wentry.k = job.item.point_curvature;
		wentry.s = job.item.point_arc;
	end

	always_comb begin
		if (32'(point_count) > 32'(MAX_POINTS)) n_eff = CW'(MAX_POINTS);
		else                                    n_eff = CW'(point_count);
		s_clamp = (job.item.query_arc > path_length) ? path_length : job.item.query_arc;
		mid     = lo_q + ((hi_q - lo_q) >> 1);
	end

	// a result leaves on an empty table, at a path end, or after the last multiply
	assign res_fire = (job_pop && job.is_query && (n_eff == '0)) ||
		(state_q == ST_LATA && edge_q) || (state_q == ST_ACC && k_q == 3'd4);

	always_comb begin
		case (state_q)
			ST_SRCH:  raddr = AW'(mid);
			ST_FETCH: begin
				if (lo_q == '0)        raddr = '0;
				else if (lo_q == n_q)  raddr = AW'(n_q - 1'b1);
				else                   raddr = AW'(lo_q - 1'b1);
			end
			ST_LATA:  raddr = AW'(lo_q);
			default:  raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[waddr] <= wentry;
		rdata_s1 <= mem_q[raddr];
	end

	// segment gap and offset from the lower point
	always_comb begin
		gap  = (rdata_s1.s > ea_q.s) ? rdata_s1.s - ea_q.s : '0;
		num  = (s_q > ea_q.s) ? s_q - ea_q.s : '0;
		rem2 = {rem_q, 1'b0};
	end

	// shared multiplier operand select
	always_comb begin
		case (k_q)
			3'd0: begin base_sel = 34'(ea_q.x); d_sel = 34'(eb_q.x) - 34'(ea_q.x); end
			3'd1: begin base_sel = 34'(ea_q.y); d_sel = 34'(eb_q.y) - 34'(ea_q.y); end
			3'd2: begin base_sel = 34'(ea_q.h); d_sel = 34'(diff_q); end
			3'd3: begin base_sel = 34'(ea_q.k); d_sel = 34'(eb_q.k) - 34'(ea_q.k); end
			default: begin
				base_sel = $signed({2'b00, ea_q.s});
				d_sel    = $signed({2'b00, eb_q.s}) - $signed({2'b00, ea_q.s});
			end
		endcase
		acc = (52'(base_s1) <<< 16) + prod_s1 + 52'sd32768;
		val = acc[51:16];
		if (val > 36'sd32767)       h_sat = 16'sh7fff;
		else if (val < -36'sd32768) h_sat = 16'sh8000;
		else                        h_sat = val[15:0];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL: begin
				prod_s1 <= 52'(d_sel) * 52'($signed({1'b0, t_q}));
				base_s1 <= base_sel;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else         result_valid <= res_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result       <= '0;
			n_q <= '0; lo_q <= '0; hi_q <= '0; mid_q <= '0;
			s_q <= '0; edge_q <= 1'b0; run_q <= 1'b0;
			ea_q <= '0; eb_q <= '0; gap_q <= '0; rem_q <= '0;
			t_q <= '0; div_cnt_q <= '0; diff_q <= '0; k_q <= '0;
			build_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_pop && job.is_query) begin
						if (n_eff == '0) begin
							result <= '{table_empty: 1'b1, default: '0};
						end else begin
							n_q     <= n_eff;
							s_q     <= s_clamp;
							lo_q    <= '0;
							hi_q    <= n_eff;
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_SCMP;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_SCMP: begin
					if (rdata_s1.s < s_q) lo_q <= mid_q + 1'b1;
					else                  hi_q <= mid_q;
					state_q <= ST_SRCH;
				end
				ST_FETCH: begin
					edge_q  <= (lo_q == '0) || (lo_q == n_q);
					state_q <= ST_LATA;
				end
				ST_LATA: begin
					ea_q <= rdata_s1;
					if (edge_q) begin
						result.out_x         <= rdata_s1.x;
						result.out_y         <= rdata_s1.y;
						result.out_heading   <= rdata_s1.h;
						result.out_curvature <= rdata_s1.k;
						result.out_arc       <= rdata_s1.s;
						result.table_empty   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LATB;
					end
				end
				ST_LATB: begin
					eb_q      <= rdata_s1;
					gap_q     <= gap;
					rem_q     <= num;
					diff_q    <= 18'(rdata_s1.h) - 18'(ea_q.h);
					div_cnt_q <= '0;
					if (gap == '0) begin
						t_q <= '0; run_q <= 1'b0;
					end else if (num >= gap) begin
						t_q <= 16'hffff; run_q <= 1'b0;
					end else begin
						t_q <= '0; run_q <= 1'b1;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// heading wrap runs alongside the quotient bits
					if (diff_q > HEAD_PI)       diff_q <= diff_q - HEAD_TWO_PI;
					else if (diff_q < -HEAD_PI) diff_q <= diff_q + HEAD_TWO_PI;
					if (run_q) begin
						if (rem2 >= {1'b0, gap_q}) begin
							rem_q <= 32'(rem2 - {1'b0, gap_q});
							t_q   <= {t_q[14:0], 1'b1};
						end else begin
							rem_q <= rem2[31:0];
							t_q   <= {t_q[14:0], 1'b0};
						end
					end
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'd15) begin
						k_q     <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					case (k_q)
						3'd0: build_q.out_x         <= val[31:0];
						3'd1: build_q.out_y         <= val[31:0];
						3'd2: build_q.out_heading   <= h_sat;
						3'd3: build_q.out_curvature <= val[15:0];
						default: ;
					endcase
					if (k_q == 3'd4) begin
						result <= '{out_x: build_q.out_x, out_y: build_q.out_y,
							out_heading: build_q.out_heading,
							out_curvature: build_q.out_curvature,
							out_arc: val[31:0], table_empty: 1'b0};
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCMP) |-> ($past(state_q) == ST_SRCH))
		else $error("search compare without a read");

	a_div_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && run_q) |-> (gap_q != '0))
		else $error("divide with zero gap");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= hi_q && hi_q <= n_q))
		else $error("search bounds crossed");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> (state_q == ST_IDLE))
		else $error("queue popped while busy");

endmodule

// ===== hw/rtl/path_point_interpolator.sv =====
// Arc-length path interpolator. A write command (func 0) stores one point in a
// MAX_POINTS-entry table; a query (func 1) returns one interpolated point on
// result, marked by result_valid for a single cycle, and the receiver must
// take it then. Commands enter a four-deep queue; busy is high only while the
// queue is full. A write is stored in the table as it is popped. A query is
// popped, then runs a binary search over the single table read port, a
// bit-serial quotient and the interpolation on the shared multiplier;
// queries at the path ends skip the quotient and multiplies, and an empty
// table answers without a search.
// Config writes (path_length, point_count) are only legal while idle.
module path_point_interpolator import ppi_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  item_t       item,
	output logic        busy,
	output logic        result_valid,
	output result_t     result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] path_length_q;
	logic [10:0] point_count_q;
	logic        job_valid, job_pop;
	job_t        job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_length_q <= '0;
			point_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATH_LENGTH: path_length_q <= cfg_data;
				REG_POINT_COUNT: point_count_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	ppi_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	ppi_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job),
		.job_pop      (job_pop),
		.path_length  (path_length_q),
		.point_count  (point_count_q),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
